// ===== hdl/scm_pkg.sv =====
// Package for the stereo correlation meter: default sizes, register indexes,
// fixed-point constants and the CORDIC arctangent table.
// No dependencies; used by the core, its checker and the bench.
`default_nettype none

package scm_pkg;

    // Defaults for the top-level parameters
    localparam int SAMPLE_BITS_DEF    = 24;
    localparam int CORDIC_STEPS_DEF   = 16;
    localparam int CORR_FRAC_BITS_DEF = 14;

    // Configuration register indexes and widths
    localparam int CFG_ADDR_W = 2;
    localparam int CFG_DATA_W = 23;
    localparam int COEFF_W    = 16;
    localparam int LEVEL_W    = 23;

    localparam logic [CFG_ADDR_W-1:0] REG_NEGATIVE_ONLY = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_SMOOTH_COEFF  = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_SILENCE_LEVEL = 2'd2;

    localparam logic [COEFF_W-1:0] COEFF_RESET = 16'd65000;
    localparam logic [LEVEL_W-1:0] LEVEL_RESET = 23'd1;

    // Angle units: pi/4 is 2^ANG_SHIFT
    localparam int ANG_SHIFT = 29;
    localparam int ANG_W     = 32;

    // CORDIC datapath: operands are normalised until the larger reaches 2^NORM_EXP
    localparam int XW          = 45;
    localparam int NORM_EXP    = 40;
    localparam int NORM_COARSE = 32;
    localparam int NORM_MID    = 36;
    localparam int ITER_W      = 5;

    // atan(2^-i) in angle units
    function automatic logic signed [ANG_W-1:0] atan_entry(input logic [ITER_W-1:0] idx);
        logic signed [ANG_W-1:0] v;
        case (idx)
            5'd0:  v = 32'sd536870912;
            5'd1:  v = 32'sd316933406;
            5'd2:  v = 32'sd167458907;
            5'd3:  v = 32'sd85004756;
            5'd4:  v = 32'sd42667331;
            5'd5:  v = 32'sd21354465;
            5'd6:  v = 32'sd10679838;
            5'd7:  v = 32'sd5340245;
            5'd8:  v = 32'sd2670163;
            5'd9:  v = 32'sd1335087;
            5'd10: v = 32'sd667544;
            5'd11: v = 32'sd333772;
            5'd12: v = 32'sd166886;
            5'd13: v = 32'sd83443;
            5'd14: v = 32'sd41722;
            5'd15: v = 32'sd20861;
            5'd16: v = 32'sd10430;
            5'd17: v = 32'sd5215;
            5'd18: v = 32'sd2608;
            5'd19: v = 32'sd1304;
            5'd20: v = 32'sd652;
            5'd21: v = 32'sd326;
            5'd22: v = 32'sd163;
            5'd23: v = 32'sd81;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

// ===== hdl/stereo_correlation_meter_core.sv =====
// Stereo phase correlation meter core: CORDIC angle, correlation map and
// one-pole smoother on a shared shift/add unit and one shared multiplier.
// Depends on scm_pkg.
//
// Usage:
//   s_ channel: one stereo pair per item, s_tdata = {right, left}.
//   m_ channel: one result per non-silent pair, m_tdata = {smoothed, instant}.
//   cfg channel: register writes, always ready; write only while the core is idle.
// Timing:
//   s_tready is high only while the sequencer is idle. A silent pair is
//   dropped at once and the next item can follow in the next cycle.
//   Otherwise m_tvalid rises after the normalisation shifts, at most
//   CORDIC_STEPS CORDIC iterations, the correlation map, the shared
//   multiplier states MUL_A, MUL_B and SUM, and the output load; an all-zero
//   pair skips straight to the map. A new pair is taken only once the
//   sequencer is back in idle after the output load.
//   The result waits in an output register while a new pair is processed;
//   if the receiver still stalls when the next result is ready, the
//   sequencer holds in its final state.
// Reset: registers take their reset values, smoother cleared, first pair loads it.
`default_nettype none

module stereo_correlation_meter_core #(
    parameter int SAMPLE_BITS    = scm_pkg::SAMPLE_BITS_DEF,
    parameter int CORDIC_STEPS   = scm_pkg::CORDIC_STEPS_DEF,
    parameter int CORR_FRAC_BITS = scm_pkg::CORR_FRAC_BITS_DEF
) (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    // input items; tdata fields from bit 0: left_sample, right_sample
    input  wire logic                            s_tvalid,
    output      logic                            s_tready,
    input  wire logic [((2*SAMPLE_BITS+7)/8)*8-1:0] s_tdata,
    // result items; tdata fields from bit 0: instant_corr, smoothed_corr
    output      logic                            m_tvalid,
    input  wire logic                            m_tready,
    output      logic [((2*(CORR_FRAC_BITS+2)+7)/8)*8-1:0] m_tdata,
    // configuration writes
    input  wire logic                            cfg_valid,
    output      logic                            cfg_ready,
    input  wire logic [scm_pkg::CFG_ADDR_W-1:0]  cfg_addr,
    input  wire logic [scm_pkg::CFG_DATA_W-1:0]  cfg_data
);

    localparam int CW      = CORR_FRAC_BITS + 2;
    localparam int OUT_TW  = ((2*CW+7)/8)*8;
    localparam int MAG_W   = SAMPLE_BITS + 1;
    localparam int CMP_W   = ((SAMPLE_BITS > scm_pkg::LEVEL_W) ?
                              SAMPLE_BITS : scm_pkg::LEVEL_W) + 1;
    localparam int SW      = CORR_FRAC_BITS + 19;
    localparam int PW      = SW + 18;
    localparam int XW      = scm_pkg::XW;
    localparam int ANG_W   = scm_pkg::ANG_W;
    localparam int ANG_DROP = scm_pkg::ANG_SHIFT - CORR_FRAC_BITS;

    localparam logic signed [ANG_W-1:0] ANG_MAX  = ANG_W'(2) <<< scm_pkg::ANG_SHIFT;
    localparam logic signed [ANG_W-1:0] ANG_RND  = ANG_W'(1) <<< (ANG_DROP - 1);
    localparam logic signed [ANG_W-1:0] CORR_OFS = ANG_W'(1) <<< CORR_FRAC_BITS;
    localparam logic signed [PW-1:0]    P_HALF   = PW'(32768);
    localparam logic signed [SW-1:0]    S_HALF   = SW'(32768);
    localparam logic [scm_pkg::ITER_W-1:0] LAST_ITER = scm_pkg::ITER_W'(CORDIC_STEPS - 1);

    typedef enum logic [2:0] {
        ST_IDLE, ST_NORM, ST_ITER, ST_CORR, ST_MUL_A, ST_MUL_B, ST_SUM, ST_FIN
    } state_t;

    state_t state_reg;

    // configuration registers
    logic                          neg_only_reg;
    logic [scm_pkg::COEFF_W-1:0]   coeff_reg;
    logic [scm_pkg::LEVEL_W-1:0]   level_reg;

    // datapath registers
    logic signed [XW-1:0]          x_reg, y_reg;
    logic signed [ANG_W-1:0]       z_reg;
    logic [scm_pkg::ITER_W-1:0]    iter_reg;
    logic                          zero_reg;
    logic signed [CW-1:0]          corr_reg;
    logic signed [SW-1:0]          s_reg;
    logic                          first_reg;
    logic signed [PW-1:0]          prod_reg, acc_reg;
    logic                          m_tvalid_reg;
    logic signed [CW-1:0]          inst_out_reg, smooth_out_reg;

    // input unpacking, magnitudes, silence test
    logic signed [SAMPLE_BITS-1:0] left_s, right_s;
    logic [SAMPLE_BITS-1:0]        abs_l, abs_r;
    logic signed [MAG_W-1:0]       sum_s, dif_s;
    logic [MAG_W-1:0]              abs_sum, abs_dif;
    logic                          silent, in_zero;

    always_comb begin
        left_s  = s_tdata[SAMPLE_BITS-1:0];
        right_s = s_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS];
        abs_l   = left_s[SAMPLE_BITS-1]  ? (~left_s + 1'b1)  : left_s;
        abs_r   = right_s[SAMPLE_BITS-1] ? (~right_s + 1'b1) : right_s;
        silent  = (CMP_W'(abs_l) < CMP_W'(level_reg)) &&
                  (CMP_W'(abs_r) < CMP_W'(level_reg));
        in_zero = (left_s == '0) && (right_s == '0);
        sum_s   = MAG_W'(left_s) + MAG_W'(right_s);
        dif_s   = MAG_W'(left_s) - MAG_W'(right_s);
        abs_sum = sum_s[MAG_W-1] ? (~sum_s + 1'b1) : sum_s;
        abs_dif = dif_s[MAG_W-1] ? (~dif_s + 1'b1) : dif_s;
    end

    // normalisation: coarse and fine shifts of both operands together
    logic [XW-1:0] xy_or;
    logic [2:0]    norm_sel;  // one-hot: shift 8, shift 4, shift 1
    always_comb begin
        xy_or    = x_reg | y_reg;
        norm_sel = 3'b000;
        if (xy_or[XW-1:scm_pkg::NORM_COARSE] == '0) begin
            norm_sel = 3'b100;
        end else if (xy_or[XW-1:scm_pkg::NORM_MID] == '0) begin
            norm_sel = 3'b010;
        end else if (xy_or[XW-1:scm_pkg::NORM_EXP] == '0) begin
            norm_sel = 3'b001;
        end
    end

    // shared CORDIC add/shift unit
    logic signed [XW-1:0]    x_sh, y_sh, x_step, y_step;
    logic signed [ANG_W-1:0] z_step, ang_i;
    always_comb begin
        x_sh  = x_reg >>> iter_reg;
        y_sh  = y_reg >>> iter_reg;
        ang_i = scm_pkg::atan_entry(iter_reg);
        if (!y_reg[XW-1]) begin
            x_step = x_reg + y_sh;
            y_step = y_reg - x_sh;
            z_step = z_reg + ang_i;
        end else begin
            x_step = x_reg - y_sh;
            y_step = y_reg + x_sh;
            z_step = z_reg - ang_i;
        end
    end

    // angle clamp and map to correlation
    logic signed [ANG_W-1:0] z_cl, z_rnd, corr_full;
    logic signed [CW-1:0]    corr_v;
    always_comb begin
        if (z_reg[ANG_W-1]) begin
            z_cl = '0;
        end else if (z_reg > ANG_MAX) begin
            z_cl = ANG_MAX;
        end else begin
            z_cl = z_reg;
        end
        z_rnd     = (z_cl + ANG_RND) >>> ANG_DROP;
        corr_full = z_rnd - CORR_OFS;
        corr_v    = zero_reg ? '0 : corr_full[CW-1:0];
        if (neg_only_reg && !corr_v[CW-1] && (corr_v != '0)) begin
            corr_v = '0;
        end
    end

    // shared multiplier: a*s, then (1-a)*corr
    logic signed [SW-1:0]    op_a;
    logic [16:0]             op_b;
    logic signed [17:0]      op_b_s;
    logic signed [PW-1:0]    prod_next, total, total_sh;
    logic signed [SW-1:0]    sm_full;
    always_comb begin
        if (state_reg == ST_MUL_A) begin
            op_a = s_reg;
            op_b = {1'b0, coeff_reg};
        end else begin
            op_a = {{(SW-CW){corr_reg[CW-1]}}, corr_reg};
            op_b = 17'h10000 - {1'b0, coeff_reg};
        end
        op_b_s    = {1'b0, op_b};
        prod_next = op_a * op_b_s;
        total     = acc_reg + (prod_reg <<< 16) + P_HALF;
        total_sh  = total >>> 16;
        sm_full   = (s_reg + S_HALF) >>> 16;
    end

    assign s_tready  = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = OUT_TW'({smooth_out_reg, inst_out_reg});

    // sequencer, datapath and output register
    always_ff @(posedge aclk) begin
        prod_reg <= prod_next;
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            neg_only_reg <= 1'b0;
            coeff_reg    <= scm_pkg::COEFF_RESET;
            level_reg    <= scm_pkg::LEVEL_RESET;
            s_reg        <= '0;
            first_reg    <= 1'b1;
            m_tvalid_reg <= 1'b0;
        end else begin
            // configuration writes
            if (cfg_valid) begin
                case (cfg_addr)
                    scm_pkg::REG_NEGATIVE_ONLY: neg_only_reg <= cfg_data[0];
                    scm_pkg::REG_SMOOTH_COEFF:  coeff_reg    <= cfg_data[scm_pkg::COEFF_W-1:0];
                    scm_pkg::REG_SILENCE_LEVEL: level_reg    <= cfg_data;
                    default: ;
                endcase
            end

            // output register: loaded from the final state, cleared when taken
            if ((state_reg == ST_FIN) && (!m_tvalid_reg || m_tready)) begin
                m_tvalid_reg   <= 1'b1;
                inst_out_reg   <= corr_reg;
                smooth_out_reg <= sm_full[CW-1:0];
            end else if (m_tvalid_reg && m_tready) begin
                m_tvalid_reg <= 1'b0;
            end

            case (state_reg)
                ST_IDLE: begin
                    if (s_tvalid && !silent) begin
                        x_reg    <= XW'(abs_dif);
                        y_reg    <= XW'(abs_sum);
                        z_reg    <= '0;
                        iter_reg <= '0;
                        zero_reg <= in_zero;
                        state_reg <= in_zero ? ST_CORR : ST_NORM;
                    end
                end
                ST_NORM: begin
                    case (norm_sel)
                        3'b100: begin
                            x_reg <= x_reg <<< 8;
                            y_reg <= y_reg <<< 8;
                        end
                        3'b010: begin
                            x_reg <= x_reg <<< 4;
                            y_reg <= y_reg <<< 4;
                        end
                        3'b001: begin
                            x_reg <= x_reg <<< 1;
                            y_reg <= y_reg <<< 1;
                        end
                        default: state_reg <= ST_ITER;
                    endcase
                end
                ST_ITER: begin
                    if (y_reg == '0) begin
                        state_reg <= ST_CORR;
                    end else begin
                        x_reg <= x_step;
                        y_reg <= y_step;
                        z_reg <= z_step;
                        iter_reg <= iter_reg + 1'b1;
                        if (iter_reg == LAST_ITER) begin
                            state_reg <= ST_CORR;
                        end
                    end
                end
                ST_CORR: begin
                    corr_reg <= corr_v;
                    // first pair after reset loads the smoother
                    if (first_reg) begin
                        s_reg     <= {{(SW-CW-16){corr_v[CW-1]}}, corr_v, 16'b0};
                        first_reg <= 1'b0;
                    end
                    state_reg <= ST_MUL_A;
                end
                ST_MUL_A: begin
                    state_reg <= ST_MUL_B;
                end
                ST_MUL_B: begin
                    acc_reg   <= prod_reg;
                    state_reg <= ST_SUM;
                end
                ST_SUM: begin
                    s_reg     <= total_sh[SW-1:0];
                    state_reg <= ST_FIN;
                end
                ST_FIN: begin
                    // leave once the output register can take the result
                    if (!m_tvalid_reg || m_tready) begin
                        state_reg <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

endmodule

`default_nettype wire

// ===== hdl/scm_checker.sv =====
// Port-level checker for the stereo correlation meter core, with its bind.
// Depends on scm_pkg and stereo_correlation_meter_core.
`default_nettype none

module scm_checker #(
    parameter int SAMPLE_BITS    = scm_pkg::SAMPLE_BITS_DEF,
    parameter int CORR_FRAC_BITS = scm_pkg::CORR_FRAC_BITS_DEF
) (
    input wire logic                            aclk,
    input wire logic                            aresetn,
    input wire logic                            s_tvalid,
    input wire logic                            s_tready,
    input wire logic [((2*SAMPLE_BITS+7)/8)*8-1:0] s_tdata,
    input wire logic                            m_tvalid,
    input wire logic                            m_tready,
    input wire logic [((2*(CORR_FRAC_BITS+2)+7)/8)*8-1:0] m_tdata,
    input wire logic                            cfg_ready
);

    localparam int CW = CORR_FRAC_BITS + 2;
    localparam logic signed [CW-1:0] CORR_HI = CW'(1) <<< CORR_FRAC_BITS;
    localparam logic signed [CW-1:0] CORR_LO = -CORR_HI;

    logic signed [CW-1:0] inst_w;
    logic                 in_acc;
    assign inst_w = m_tdata[CW-1:0];
    assign in_acc = s_tvalid && s_tready && (s_tdata == s_tdata);

    // reset leaves the core ready with no result pending
    a_reset: assert property (@(posedge aclk) !aresetn |=> s_tready && !m_tvalid)
        else $error("core not idle after reset");

    // a stalled result item holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result item changed");

    // no result can appear in the cycle after an item is taken
    a_latency: assert property (@(posedge aclk) disable iff (!aresetn)
        in_acc |=> !$rose(m_tvalid))
        else $error("result appeared too early");

    // instant correlation stays within -1..+1
    a_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (inst_w >= CORR_LO) && (inst_w <= CORR_HI))
        else $error("instant correlation out of range");

    // configuration channel never stalls
    a_cfg: assert property (@(posedge aclk) disable iff (!aresetn) cfg_ready)
        else $error("configuration channel stalled");

endmodule

bind stereo_correlation_meter_core scm_checker #(
    .SAMPLE_BITS(SAMPLE_BITS),
    .CORR_FRAC_BITS(CORR_FRAC_BITS)
) u_scm_checker (
    .aclk(aclk),
    .aresetn(aresetn),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata),
    .cfg_ready(cfg_ready)
);

`default_nettype wire

// ===== verif/tb.sv =====
// Self-checking bench for stereo_correlation_meter_core: random stereo pairs in,
// instant and smoothed correlation checked against an in-bench CORDIC predictor.
// Depends on scm_pkg and the core; register writes only while the core is idle.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SMP_W  = scm_pkg::SAMPLE_BITS_DEF;
    localparam int FRAC   = scm_pkg::CORR_FRAC_BITS_DEF;
    localparam int CORR_W = scm_pkg::CORR_FRAC_BITS_DEF + 2;
    localparam int STEPS  = scm_pkg::CORDIC_STEPS_DEF;
    localparam int S_W    = ((2 * SMP_W + 7) / 8) * 8;
    localparam int M_W    = ((2 * CORR_W + 7) / 8) * 8;

    localparam longint SMP_MAX    = (longint'(1) << (SMP_W - 1)) - 1;
    localparam longint SMP_MIN    = -(longint'(1) << (SMP_W - 1));
    localparam longint NORM_LIMIT = longint'(1) << scm_pkg::NORM_EXP;
    localparam longint ANGLE_TOP  = longint'(1) << (scm_pkg::ANG_SHIFT + 1);
    localparam int     SETTLE_CYCLES = 64;

    // atan(2^-i), pi/4 = 2^29
    localparam longint ATAN_STEP [24] = '{
        536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
        10679838, 5340245, 2670163, 1335087, 667544, 333772,
        166886, 83443, 41722, 20861, 10430, 5215,
        2608, 1304, 652, 326, 163, 81
    };

    typedef struct packed {
        logic signed [SMP_W-1:0] right_sample;
        logic signed [SMP_W-1:0] left_sample;
    } stereo_pair_t;

    typedef struct packed {
        logic signed [CORR_W-1:0] smoothed_corr;
        logic signed [CORR_W-1:0] instant_corr;
    } corr_result_t;

    logic                           aclk      = 1'b0;
    logic                           aresetn   = 1'b0;
    logic                           s_tvalid  = 1'b0;
    logic                           s_tready;
    logic [S_W-1:0]                 s_tdata   = '0;   // left_sample, right_sample
    logic                           m_tvalid;
    logic                           m_tready  = 1'b0;
    logic [M_W-1:0]                 m_tdata;          // instant_corr, smoothed_corr
    logic                           cfg_valid = 1'b0;
    logic                           cfg_ready;
    logic [scm_pkg::CFG_ADDR_W-1:0] cfg_addr  = '0;
    logic [scm_pkg::CFG_DATA_W-1:0] cfg_data  = '0;

    stereo_correlation_meter_core dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_addr  (cfg_addr),
        .cfg_data  (cfg_data)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    stereo_pair_t pair_queue[$];
    corr_result_t corr_expected[$];
    int           mismatches = 0;
    bit           no_idle    = 1'b0;
    int           send_gap   = 0;
    int           stall_left = 0;

    // predictor copy of registers and smoother state
    logic                          neg_only_q   = 1'b0;
    logic [scm_pkg::COEFF_W-1:0]   coeff_q      = scm_pkg::COEFF_RESET;
    logic [scm_pkg::LEVEL_W-1:0]   level_q      = scm_pkg::LEVEL_RESET;
    longint                        smoother_acc = 0;
    bit                            load_pending = 1'b1;

    // mostly short gaps, a few long ones
    function automatic int pick_gap();
        int roll;
        if (no_idle) return 0;
        roll = $urandom_range(0, 99);
        if (roll < 55) return 0;
        if (roll < 85) return $urandom_range(1, 3);
        if (roll < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic bit pair_is_quiet(input stereo_pair_t p, input longint lvl);
        longint al, ar;
        al = p.left_sample;
        ar = p.right_sample;
        if (al < 0) al = -al;
        if (ar < 0) ar = -ar;
        return (al < lvl) && (ar < lvl);
    endfunction

    // vectoring CORDIC on (|l-r|, |l+r|), angle in pi/4 = 2^29 units
    function automatic longint fold_angle(input longint x, input longint y);
        longint z, nx, ny;
        z = 0;
        while (x < NORM_LIMIT && y < NORM_LIMIT) begin
            x = x <<< 1;
            y = y <<< 1;
        end
        for (int i = 0; i < STEPS; i++) begin
            if (y == 0) break;
            if (y > 0) begin
                nx = x + (y >>> i);
                ny = y - (x >>> i);
                z  = z + ATAN_STEP[i];
            end else begin
                nx = x - (y >>> i);
                ny = y + (x >>> i);
                z  = z - ATAN_STEP[i];
            end
            x = nx;
            y = ny;
        end
        if (z < 0) z = 0;
        if (z > ANGLE_TOP) z = ANGLE_TOP;
        return z;
    endfunction

    // returns 1 and the result item for a non-silent pair; advances the smoother
    function automatic bit predict_corr(input stereo_pair_t p, output corr_result_t res);
        longint l, r, sum, dif, corr, xs, a, sm;
        l = p.left_sample;
        r = p.right_sample;
        res = '0;
        if (pair_is_quiet(p, longint'(level_q))) return 1'b0;
        if (l == 0 && r == 0) begin
            corr = 0;
        end else begin
            sum = l + r;
            dif = l - r;
            if (sum < 0) sum = -sum;
            if (dif < 0) dif = -dif;
            corr = ((fold_angle(dif, sum) + (longint'(1) << (scm_pkg::ANG_SHIFT - 1 - FRAC)))
                    >>> (scm_pkg::ANG_SHIFT - FRAC)) - (longint'(1) << FRAC);
        end
        if (neg_only_q && corr > 0) corr = 0;
        xs = corr * 65536;
        if (load_pending) begin
            load_pending = 1'b0;
            smoother_acc = xs;
        end
        a = longint'(coeff_q);
        smoother_acc = (a * smoother_acc + (65536 - a) * xs + 32768) >>> 16;
        sm = (smoother_acc + 32768) >>> 16;
        res.instant_corr  = corr[CORR_W-1:0];
        res.smoothed_corr = sm[CORR_W-1:0];
        return 1'b1;
    endfunction

    // sender: next pair from the queue, random gap after each accepted item
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || s_tready) begin
            if (send_gap > 0) begin
                send_gap = send_gap - 1;
                s_tvalid <= 1'b0;
            end else if (pair_queue.size() > 0) begin
                s_tdata  <= pair_queue.pop_front();
                s_tvalid <= 1'b1;
                send_gap = pick_gap();
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // expected results, worked out as each pair is accepted
    always @(posedge aclk) begin
        corr_result_t res;
        if (aresetn && s_tvalid && s_tready) begin
            if (predict_corr(stereo_pair_t'(s_tdata), res)) corr_expected.push_back(res);
        end
    end

    // register shadow
    always @(posedge aclk) begin
        if (aresetn && cfg_valid && cfg_ready) begin
            case (cfg_addr)
                scm_pkg::REG_NEGATIVE_ONLY: neg_only_q <= cfg_data[0];
                scm_pkg::REG_SMOOTH_COEFF:  coeff_q    <= cfg_data[scm_pkg::COEFF_W-1:0];
                scm_pkg::REG_SILENCE_LEVEL: level_q    <= cfg_data[scm_pkg::LEVEL_W-1:0];
                default: ;
            endcase
        end
    end

    // receiver: check each result item, random stalls
    always @(posedge aclk) begin
        corr_result_t got, want;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                got = corr_result_t'(m_tdata);
                if (corr_expected.size() == 0) begin
                    $error("unexpected result item: instant_corr %0d smoothed_corr %0d",
                           got.instant_corr, got.smoothed_corr);
                    mismatches++;
                end else begin
                    want = corr_expected.pop_front();
                    if (got.instant_corr !== want.instant_corr) begin
                        $error("instant_corr: expected %0d, got %0d",
                               want.instant_corr, got.instant_corr);
                        mismatches++;
                    end
                    if (got.smoothed_corr !== want.smoothed_corr) begin
                        $error("smoothed_corr: expected %0d, got %0d",
                               want.smoothed_corr, got.smoothed_corr);
                        mismatches++;
                    end
                end
            end
            if (stall_left > 0) begin
                stall_left = stall_left - 1;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
                stall_left = pick_gap();
            end
        end
    end

    function automatic longint rand_sample();
        logic signed [SMP_W-1:0] v;
        v = SMP_W'($urandom);
        return longint'(v);
    endfunction

    function automatic longint pick_extreme();
        case ($urandom_range(0, 4))
            0: return SMP_MAX;
            1: return SMP_MIN;
            2: return 0;
            3: return 1;
            default: return -1;
        endcase
    endfunction

    function automatic logic signed [SMP_W-1:0] clip_sample(input longint v);
        if (v > SMP_MAX) v = SMP_MAX;
        else if (v < SMP_MIN) v = SMP_MIN;
        return SMP_W'(v);
    endfunction

    // random pair: noise, near-mono, near-anti-phase, one-sided, near silence, extremes, scaled-down noise
    function automatic stereo_pair_t random_pair();
        stereo_pair_t p;
        longint l, r, amp;
        l = rand_sample();
        r = rand_sample();
        case ($urandom_range(0, 9))
            0, 1, 2: ;
            3: r = l + (rand_sample() >>> $urandom_range(6, 23));
            4: r = -l + (rand_sample() >>> $urandom_range(6, 23));
            5: begin
                if ($urandom_range(0, 1)) r = rand_sample() >>> $urandom_range(16, 23);
                else l = rand_sample() >>> $urandom_range(16, 23);
            end
            6: begin
                amp = longint'(level_q) * 2 + 8;
                l = longint'($urandom_range(0, 32'(2 * amp))) - amp;
                r = longint'($urandom_range(0, 32'(2 * amp))) - amp;
            end
            7: begin
                l = pick_extreme();
                r = pick_extreme();
            end
            default: begin
                l = l >>> $urandom_range(0, 23);
                r = r >>> $urandom_range(0, 23);
            end
        endcase
        p.left_sample  = clip_sample(l);
        p.right_sample = clip_sample(r);
        return p;
    endfunction

    task automatic push_pair(input longint l, input longint r);
        stereo_pair_t p;
        p.left_sample  = clip_sample(l);
        p.right_sample = clip_sample(r);
        pair_queue.push_back(p);
    endtask

    task automatic write_reg(input logic [scm_pkg::CFG_ADDR_W-1:0] idx,
                             input logic [scm_pkg::CFG_DATA_W-1:0] value);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_addr  <= idx;
        cfg_data  <= value;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    // unused upper bits carry junk, the core must mask them
    task automatic apply_settings(input logic neg, input logic [scm_pkg::COEFF_W-1:0] coeff,
                                  input logic [scm_pkg::LEVEL_W-1:0] level);
        write_reg(scm_pkg::REG_NEGATIVE_ONLY, {(scm_pkg::CFG_DATA_W-1)'($urandom), neg});
        write_reg(scm_pkg::REG_SMOOTH_COEFF,
                  {(scm_pkg::CFG_DATA_W-scm_pkg::COEFF_W)'($urandom), coeff});
        write_reg(scm_pkg::REG_SILENCE_LEVEL, scm_pkg::CFG_DATA_W'(level));
        @(negedge aclk);
    endtask

    // all pairs sent, all results back, then room for a pair still in flight
    task automatic wait_idle();
        do @(posedge aclk);
        while (pair_queue.size() != 0 || s_tvalid || corr_expected.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge aclk);
        @(negedge aclk);
    endtask

    // random pairs until 'quota' non-silent ones are queued
    task automatic run_phase(input int quota);
        stereo_pair_t p;
        int counted;
        longint lvl;
        counted = 0;
        lvl = longint'(level_q);
        while (counted < quota) begin
            p = random_pair();
            // with a high silence level, force a full-scale channel often
            if (lvl > SMP_MAX / 2 && $urandom_range(0, 1)) begin
                if ($urandom_range(0, 1)) p.left_sample = clip_sample(
                    $urandom_range(0, 1) ? SMP_MAX : SMP_MIN);
                else p.right_sample = clip_sample(
                    $urandom_range(0, 1) ? SMP_MAX : SMP_MIN);
            end
            if (!pair_is_quiet(p, lvl)) counted++;
            pair_queue.push_back(p);
        end
        wait_idle();
    endtask

    initial begin
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // reset settings: silent zero, mono, anti-phase, one channel, full scale
        push_pair(0, 0);
        push_pair(1, 1);
        push_pair(SMP_MAX, SMP_MAX);
        push_pair(SMP_MIN, SMP_MIN);
        push_pair(SMP_MAX, SMP_MIN);
        push_pair(SMP_MIN, SMP_MAX);
        push_pair(SMP_MAX, 0);
        push_pair(0, SMP_MIN);
        push_pair(1, -1);
        push_pair(-1, 0);
        push_pair(12345, -6789);
        push_pair(-4000000, -3999999);
        wait_idle();

        // no silence gate: zero pair is processed
        apply_settings(1'b0, scm_pkg::COEFF_RESET, '0);
        push_pair(0, 0);
        push_pair(0, -1);
        wait_idle();

        // negative-only clamp, no smoothing
        apply_settings(1'b1, '0, '0);
        push_pair(SMP_MAX, SMP_MAX);
        push_pair(300, 200);
        push_pair(-300, 300);
        push_pair(0, 0);
        wait_idle();

        // highest silence level, heaviest smoothing
        apply_settings(1'b0, '1, '1);
        push_pair(SMP_MAX - 1, SMP_MAX - 1);
        push_pair(SMP_MAX, 0);
        push_pair(0, SMP_MIN);
        push_pair(SMP_MIN, SMP_MAX);
        wait_idle();

        // random phases over several settings
        apply_settings(1'b0, scm_pkg::COEFF_RESET, scm_pkg::LEVEL_RESET);
        run_phase(300);
        apply_settings(1'b1, '0, '0);
        run_phase(300);
        apply_settings(1'b0, '1, scm_pkg::LEVEL_W'($urandom_range(1, 4096)));
        run_phase(300);
        apply_settings(1'($urandom), scm_pkg::COEFF_W'($urandom), '1);
        run_phase(60);
        no_idle = 1'b1;
        apply_settings(1'b0, scm_pkg::COEFF_W'($urandom), '0);
        run_phase(300);
        no_idle = 1'b0;
        apply_settings(1'b1, scm_pkg::COEFF_RESET, scm_pkg::LEVEL_W'($urandom_range(0, 255)));
        run_phase(300);
        apply_settings(1'($urandom), scm_pkg::COEFF_W'($urandom),
                       scm_pkg::LEVEL_W'($urandom_range(0, 65536)));
        run_phase(300);

        if (mismatches == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

    // watchdog
    initial begin
        #10_000_000;
        $display("end of test: mismatches");
        $finish;
    end

endmodule

// ===== sim.f =====
hdl/scm_pkg.sv
hdl/stereo_correlation_meter_core.sv
hdl/scm_checker.sv
verif/tb.sv
